// ----- design/bwc_pkg.sv -----
// Shared types, widths and constants of the battery window classifier.
package bwc_pkg;

	localparam int WINDOW_DEPTH = 10;

	localparam int RAW_W    = 10;
	localparam int PCT_W    = 8;
	localparam int SAMPLE_W = 12;
	localparam int VSCALE_W = 11;
	localparam int CENTI_W  = 14;
	localparam int STATUS_W = 2;

	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 32;
	localparam int CFG_ADDR_W  = 3;
	localparam int CFG_DATA_W  = 12;

	// window bookkeeping
	localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
	localparam int IDX_W  = (WINDOW_DEPTH > 2) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int SUM_W  = $clog2(WINDOW_DEPTH * 4095 + 1);

	localparam logic [FILL_W-1:0] FILL_FULL = (FILL_W)'(WINDOW_DEPTH);
	localparam logic [IDX_W-1:0]  WALK_LAST = (IDX_W)'(WINDOW_DEPTH - 1);

	// raw * percent / 100: exact floor for products below 2^18
	localparam int CAL_PROD_W = RAW_W + PCT_W;
	localparam int CAL_SHIFT  = 26;
	localparam int CAL_RECIP_W = 20;
	localparam logic [CAL_RECIP_W-1:0] CAL_RECIP = 20'd671089;

	// sum / WINDOW_DEPTH: exact floor for any sum below 2^SUM_W
	localparam int AVG_SHIFT = SUM_W + FILL_W;
	localparam longint unsigned AVG_RECIP_L =
		((64'd1 << AVG_SHIFT) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);
	localparam logic [AVG_SHIFT-1:0] AVG_RECIP = AVG_RECIP_L[AVG_SHIFT-1:0];

	// avg * volts_scale / 1000: exact floor for products below 2^23
	localparam int CPROD_W = SAMPLE_W + VSCALE_W;
	localparam int CENTI_SHIFT = 33;
	localparam int CENTI_RECIP_W = 24;
	localparam logic [CENTI_RECIP_W-1:0] CENTI_RECIP = 24'd8589935;

	// configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_CAL_PERCENT    = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_LOW_THRESHOLD  = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_FULL_THRESHOLD = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_VOLTS_SCALE    = 3'd3;

	// battery status codes
	localparam logic [STATUS_W-1:0] STATUS_UNKNOWN = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_LOW     = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_GOOD    = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_PUSH,
		ST_WALK,
		ST_AVG,
		ST_SCALE,
		ST_DONE
	} bwc_state_t;

endpackage

// ----- design/bwc_cell.sv -----
// One slot of the sample window chain: loads its neighbor's value on shift.
module bwc_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         shift,
	input  logic [bwc_pkg::SAMPLE_W-1:0] d,
	output logic [bwc_pkg::SAMPLE_W-1:0] q
);
	import bwc_pkg::*;

	logic [SAMPLE_W-1:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else if (shift) begin
			value_q <= d;
		end
	end

	assign q = value_q;

endmodule

// ----- design/battery_window_classifier.sv -----
// Top level of the battery window classifier: control, chain of window cells, datapath.
//
//  channel  | direction | handshake                     | payload
//  ---------+-----------+-------------------------------+---------------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready | raw_sample
//  m_axis   | out       | m_axis_tvalid / m_axis_tready | status, full, max, centivolts
//  cfg      | in        | cfg_we (no wait)              | cfg_addr selects, cfg_wdata
//
//  Steps: while the window fills, an accepted request runs IDLE, MUL, PUSH and DONE; from the
//  push that fills the window on, each push is followed by WALK, AVG and SCALE before DONE.
//  A new request is taken only in IDLE, so the block takes no new sample before it is through
//  with the last. The walk rotates the cell chain once around, one cell per cycle, to gather
//  sum and maximum.
//  Reset: clears the window, fill count, status (unknown) and loads register defaults.
//  Stalls: the result sits in an output register; a new request is taken while it
//  waits, and the block holds in its last step only if the previous result is unread.
module battery_window_classifier (
	input  logic                               clk,
	input  logic                               arst_n,
	// stream in
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [bwc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [9:0] raw_sample
	// stream out
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [bwc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // [1:0] battery_status,
	                                                          // [2] window_full,
	                                                          // [14:3] window_max,
	                                                          // [28:15] centivolts
	// configuration
	input  logic                               cfg_we,
	input  logic [bwc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [bwc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import bwc_pkg::*;

	// configuration registers
	logic [PCT_W-1:0]    cal_percent_q;
	logic [SAMPLE_W-1:0] low_threshold_q;
	logic [SAMPLE_W-1:0] full_threshold_q;
	logic [VSCALE_W-1:0] volts_scale_q;

	// control
	bwc_state_t        state_q, state_d;
	logic [FILL_W-1:0] fill_q;
	logic [IDX_W-1:0]  walk_q;
	logic              out_valid_q;
	logic              out_free;
	logic              load_out;
	logic              chain_shift;
	logic              chain_load_new;
	logic              window_full;

	// datapath
	logic [RAW_W-1:0]                      raw_q;
	logic [CAL_PROD_W-1:0]                 cal_prod_q;
	logic [CAL_PROD_W+CAL_RECIP_W-1:0]     cal_quot_prod;
	logic [SAMPLE_W-1:0]                   cal_sample;
	logic [SUM_W-1:0]                      sum_q;
	logic [SAMPLE_W-1:0]                   max_q;
	logic [SUM_W+AVG_SHIFT-1:0]            avg_prod;
	logic [SAMPLE_W-1:0]                   avg_q;
	logic [CPROD_W-1:0]                    cprod_q;
	logic [CPROD_W+CENTI_RECIP_W-1:0]      centi_prod;
	logic [CENTI_W-1:0]                    centi_new;
	logic [STATUS_W-1:0]                   status_new;

	// output register
	logic [STATUS_W-1:0] out_status_q;
	logic                out_full_q;
	logic [SAMPLE_W-1:0] out_max_q;
	logic [CENTI_W-1:0]  out_centi_q;

	// chain of cells
	logic [SAMPLE_W-1:0] cell_d [WINDOW_DEPTH];
	logic [SAMPLE_W-1:0] cell_q [WINDOW_DEPTH];
	logic [SAMPLE_W-1:0] tail;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_percent_q    <= 8'd100;
			low_threshold_q  <= 12'd329;
			full_threshold_q <= 12'd423;
			volts_scale_q    <= 11'd1063;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_CAL_PERCENT:    cal_percent_q    <= cfg_wdata[PCT_W-1:0];
				REG_LOW_THRESHOLD:  low_threshold_q  <= cfg_wdata[SAMPLE_W-1:0];
				REG_FULL_THRESHOLD: full_threshold_q <= cfg_wdata[SAMPLE_W-1:0];
				REG_VOLTS_SCALE:    volts_scale_q    <= cfg_wdata[VSCALE_W-1:0];
				default: ;  // drop writes beyond the register list
			endcase
		end
	end

	// ---------------------------------------------------------------- FSM
	assign out_free    = !out_valid_q || m_axis_tready;
	assign window_full = (fill_q == FILL_FULL);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (s_axis_tvalid) state_d = ST_MUL;
			ST_MUL:   state_d = ST_PUSH;
			// fill_q still holds the count before this push
			ST_PUSH:  state_d = (fill_q >= FILL_FULL - 1'b1) ? ST_WALK : ST_DONE;
			ST_WALK:  if (walk_q == WALK_LAST) state_d = ST_AVG;
			ST_AVG:   state_d = ST_SCALE;
			ST_SCALE: state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready  = 1'b0;
		chain_shift    = 1'b0;
		chain_load_new = 1'b0;
		load_out       = 1'b0;
		case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_PUSH: begin
				chain_shift    = 1'b1;
				chain_load_new = 1'b1;
			end
			ST_WALK: chain_shift = 1'b1;
			ST_DONE: load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			walk_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_PUSH) begin
				walk_q <= '0;
				if (!window_full) fill_q <= fill_q + 1'b1;
			end else if (state_q == ST_WALK) begin
				walk_q <= walk_q + 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- calibration
	// The quotient of an 18-bit product by 100 stays below 4096, so it never saturates.
	assign cal_quot_prod = cal_prod_q * CAL_RECIP;
	assign cal_sample    = cal_quot_prod[CAL_SHIFT+SAMPLE_W-1:CAL_SHIFT];

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			raw_q <= s_axis_tdata[RAW_W-1:0];
		end
		if (state_q == ST_MUL) begin
			cal_prod_q <= raw_q * cal_percent_q;
		end
	end

	// ---------------------------------------------------------------- window chain
	// Push shifts the new sample in at the head; the walk rotates the tail back to
	// the head, so after WINDOW_DEPTH steps every cell holds its value again.
	assign tail = cell_q[WINDOW_DEPTH-1];

	for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign cell_d[i] = chain_load_new ? cal_sample : tail;
		end else begin : g_body
			assign cell_d[i] = cell_q[i-1];
		end
		bwc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (chain_shift),
			.d      (cell_d[i]),
			.q      (cell_q[i])
		);
	end

	// ---------------------------------------------------------------- sum, max, scaling
	assign avg_prod   = sum_q * AVG_RECIP;
	assign centi_prod = cprod_q * CENTI_RECIP;
	// at most 4095 * 2047 / 1000, well below the 14-bit ceiling
	assign centi_new  = centi_prod[CENTI_SHIFT+CENTI_W-1:CENTI_SHIFT];

	always_comb begin
		if (max_q < low_threshold_q) begin
			status_new = STATUS_LOW;
		end else if (max_q < full_threshold_q) begin
			status_new = STATUS_GOOD;
		end else begin
			status_new = STATUS_FULL;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_PUSH: begin
				sum_q <= '0;
				max_q <= '0;
			end
			ST_WALK: begin
				sum_q <= sum_q + SUM_W'(tail);
				if (tail > max_q) max_q <= tail;
			end
			ST_AVG:   avg_q   <= avg_prod[AVG_SHIFT+SAMPLE_W-1:AVG_SHIFT];
			ST_SCALE: cprod_q <= avg_q * volts_scale_q;
			default: ;
		endcase
	end

	// ---------------------------------------------------------------- output register
	// out_status_q doubles as the kept status: hold it while the window fills.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_status_q <= STATUS_UNKNOWN;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
				if (window_full) out_status_q <= status_new;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_full_q  <= window_full;
			out_max_q   <= window_full ? max_q : '0;
			out_centi_q <= window_full ? centi_new : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {
		(OUT_TDATA_W - STATUS_W - 1 - SAMPLE_W - CENTI_W)'(0),
		out_centi_q, out_max_q, out_full_q, out_status_q
	};

	// ---------------------------------------------------------------- checks
	a_walk_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> window_full)
		else $error("window walk started before the window filled");

	a_accept_starts_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (state_q == ST_MUL))
		else $error("accepted request did not start the calibration step");

	a_max_within_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_AVG) |-> (SUM_W'(max_q) <= sum_q))
		else $error("window maximum exceeds window sum");

	a_walk_rotation_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_AVG) |-> ($past(walk_q) == WALK_LAST))
		else $error("walk left before a full rotation of the chain");

	a_fill_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q <= FILL_FULL))
		else $error("fill count ran past the window depth");

endmodule
